### rtl/pdlb_pkg.sv
// Package for the plane display list builder: word types, codes, constants.
// Shared by every RTL file of the block except pdlb_div; depends on nothing.
`default_nettype none
package pdlb_pkg;

   localparam int MAX_PLANES     = 16;
   localparam int MAX_LIST_WORDS = 4096;
   localparam int NSLOT          = 22;

   localparam logic [31:0] CTX_WORD     = 32'hc0c0c0c0;
   localparam logic [31:0] OPAQUE_ALPHA = 32'h0000fff0;
   localparam logic [31:0] FIXED_ALPHA  = 32'h40000000;
   localparam logic [31:0] END_WORD     = 32'h80000000;
   localparam logic [15:0] DIM_MAX      = 16'h1fff;
   localparam logic [15:0] X_MAX        = 16'h3fff;
   localparam logic [15:0] Y_MAX        = 16'h0fff;

   // input function codes
   localparam logic [1:0] FUNC_BEGIN  = 2'd0;
   localparam logic [1:0] FUNC_PLANE  = 2'd1;
   localparam logic [1:0] FUNC_END    = 2'd2;
   localparam logic [1:0] FUNC_IGNORE = 2'd3;

   // pixel formats and filters
   localparam logic [1:0] FMT_RGB565   = 2'd0;
   localparam logic [1:0] FMT_ARGB8888 = 2'd1;
   localparam logic [1:0] FILT_NEAREST = 2'd0;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_CAPACITY = 2'd2;
   localparam logic [1:0] ST_PLANES   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd0;
   localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd1;
   localparam logic [2:0] REG_LIST_CAPACITY  = 3'd2;
   localparam logic [2:0] REG_NEAREST_SLOT   = 3'd3;
   localparam logic [2:0] REG_MITCHELL_SLOT  = 3'd4;

   // scaling modes per axis
   localparam logic [1:0] SC_NONE = 2'd0;
   localparam logic [1:0] SC_PPF  = 2'd1;
   localparam logic [1:0] SC_TPZ  = 2'd2;

   // word slots of a plane, in emission order
   localparam logic [4:0] SLOT_HDR   = 5'd0;
   localparam logic [4:0] SLOT_POS   = 5'd1;
   localparam logic [4:0] SLOT_ALPHA = 5'd2;
   localparam logic [4:0] SLOT_DSIZE = 5'd3;
   localparam logic [4:0] SLOT_SSIZE = 5'd4;
   localparam logic [4:0] SLOT_CTX0  = 5'd5;
   localparam logic [4:0] SLOT_ADDR  = 5'd6;
   localparam logic [4:0] SLOT_CTX1  = 5'd7;
   localparam logic [4:0] SLOT_PITCH = 5'd8;
   localparam logic [4:0] SLOT_LBM   = 5'd9;
   localparam logic [4:0] SLOT_PPFH  = 5'd10;
   localparam logic [4:0] SLOT_PPFV  = 5'd11;
   localparam logic [4:0] SLOT_CTX2  = 5'd12;
   localparam logic [4:0] SLOT_TZ0H  = 5'd13;
   localparam logic [4:0] SLOT_TZ1H  = 5'd14;
   localparam logic [4:0] SLOT_TZ0V  = 5'd15;
   localparam logic [4:0] SLOT_TZ1V  = 5'd16;
   localparam logic [4:0] SLOT_CTX3  = 5'd17;
   localparam logic [4:0] SLOT_LAST  = 5'd21;

   // divider jobs
   localparam logic [1:0] DIV_SCALE_H = 2'd0;
   localparam logic [1:0] DIV_SCALE_V = 2'd1;
   localparam logic [1:0] DIV_RECIP_H = 2'd2;
   localparam logic [1:0] DIV_RECIP_V = 2'd3;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_CLEAR, ACT_ERR, ACT_END, ACT_PLANE
   } act_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  pix_format;
      logic [1:0]  scale_filter;
      logic [31:0] buffer_address;
      logic [15:0] source_width;
      logic [15:0] source_height;
      logic [15:0] place_x;
      logic [15:0] place_y;
      logic [15:0] shown_width;
      logic [15:0] shown_height;
      logic [15:0] line_pitch;
   } req_type;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
      logic [1:0]  status;
      logic [12:0] fill_count;
      logic        nearest_needed;
      logic        mitchell_needed;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       decide;
      logic       div_start;
      logic [1:0] div_sel;
      logic       div_save;
      logic       emit;
      logic [4:0] slot;
      logic       plane_done;
   } cmd_type;

   typedef struct packed {
      act_type          act;
      logic             out_free;
      logic             div_done;
      logic [NSLOT-1:0] slot_en;
   } sts_type;

   function automatic logic [2:0] scale_code(input logic [1:0] h, input logic [1:0] v);
      logic [2:0] sc;
      sc = 3'd0;
      if (h == SC_TPZ && v == SC_PPF) sc = 3'd1;
      else if (h == SC_PPF && v == SC_TPZ) sc = 3'd2;
      else if (h == SC_TPZ && v == SC_TPZ) sc = 3'd3;
      else if (h == SC_PPF && v == SC_NONE) sc = 3'd4;
      else if (h == SC_NONE && v == SC_PPF) sc = 3'd5;
      else if (h == SC_NONE && v == SC_TPZ) sc = 3'd6;
      else if (h == SC_TPZ && v == SC_NONE) sc = 3'd7;
      return sc;
   endfunction

endpackage
`default_nettype wire

### rtl/pdlb_div.sv
// Radix-2 restoring divider, 32-bit quotient and remainder, one bit a cycle.
// Uses nothing from the package.
`default_nettype none
module pdlb_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] numer,
   input  wire logic [31:0] denom,
   output logic             done,
   output logic [31:0]      quot,
   output logic [31:0]      rem
);
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[31:0], quo_ff[31]};
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff[31:0];
endmodule
`default_nettype wire

### rtl/pdlb_dp.sv
// Datapath: registers, list state, plane checks, divider and word builder.
// Depends on pdlb_pkg and pdlb_div.
`default_nettype none
module pdlb_dp import pdlb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output rsp_type          rsp
);
   logic [12:0] disp_w_ff, disp_h_ff, cap_ff;
   logic [31:0] near_slot_ff, mitch_slot_ff;
   req_type     item_ff;
   logic [12:0] words_ff;
   logic [4:0]  planes_ff;
   logic        near_ff, mitch_ff, failed_ff;
   logic [1:0]  code_ff;
   logic [1:0]  h_ff, v_ff;
   logic [4:0]  n_ff;
   logic [NSLOT-1:0] en_ff;
   logic [31:0] qh_ff, qv_ff;
   logic [12:0] rh_ff, rv_ff;
   logic [15:0] ih_ff, iv_ff;
   rsp_type     out_ff;
   logic        out_valid_ff;

   function automatic logic [1:0] pick(input logic [15:0] s, input logic [15:0] d);
      logic [1:0] m;
      if (s == d) m = SC_NONE;
      else if (18'(d) * 18'd3 >= 18'(s) * 18'd2) m = SC_PPF;
      else m = SC_TPZ;
      return m;
   endfunction

   function automatic logic [31:0] ppf_word(input logic [31:0] q, input logic [12:0] r,
                                            input logic [12:0] d, input logic nearest);
      logic [13:0] errf;
      logic [6:0]  phase;
      errf  = 14'(r) + (q[0] ? 14'(d) : 14'd0);
      phase = 7'(errf[13:11]) - 7'd32;
      return {nearest, 1'b1, 5'd0, q[16:1], 1'b0, 1'b0, phase};
   endfunction

   // plane checks
   logic        fmt4, cap_bad, bad, fits_x, fits_y, unity, any_ppf;
   logic [1:0]  h_sc, v_sc, code;
   logic [15:0] pitch_need;
   logic [NSLOT-1:0] en;
   logic [4:0]  n;
   logic [13:0] sum_n, sum_1;
   act_type     act;

   always_comb begin
      fmt4    = item_ff.pix_format == FMT_ARGB8888;
      cap_bad = cap_ff == 13'd0 || 14'(cap_ff) > 14'(MAX_LIST_WORDS);
      fits_x  = item_ff.place_x <= 16'(disp_w_ff) &&
                item_ff.shown_width <= 16'(disp_w_ff) - item_ff.place_x;
      fits_y  = item_ff.place_y <= 16'(disp_h_ff) &&
                item_ff.shown_height <= 16'(disp_h_ff) - item_ff.place_y;
      pitch_need = fmt4 ? {item_ff.source_width[13:0], 2'b00}
                        : {item_ff.source_width[14:0], 1'b0};
      bad = item_ff.buffer_address == 32'd0 || item_ff.buffer_address[0] ||
            item_ff.source_width == 16'd0 || item_ff.source_width > DIM_MAX ||
            item_ff.source_height == 16'd0 || item_ff.source_height > DIM_MAX ||
            item_ff.place_x > X_MAX || item_ff.place_y > Y_MAX ||
            item_ff.shown_width == 16'd0 || item_ff.shown_width > DIM_MAX ||
            item_ff.shown_height == 16'd0 || item_ff.shown_height > DIM_MAX ||
            disp_w_ff == 13'd0 || disp_h_ff == 13'd0 || !fits_x || !fits_y ||
            item_ff.line_pitch < pitch_need ||
            (fmt4 ? (item_ff.line_pitch[1:0] != 2'd0) : item_ff.line_pitch[0]) ||
            item_ff.pix_format[1] || item_ff.scale_filter[1];
      h_sc    = pick(item_ff.source_width, item_ff.shown_width);
      v_sc    = pick(item_ff.source_height, item_ff.shown_height);
      unity   = h_sc == SC_NONE && v_sc == SC_NONE;
      any_ppf = h_sc == SC_PPF || v_sc == SC_PPF;
      en      = {{4{any_ppf}}, {3{v_sc == SC_TPZ}}, {2{h_sc == SC_TPZ}},
                 {2{v_sc == SC_PPF}}, h_sc == SC_PPF, v_sc != SC_NONE,
                 5'b11111, !unity, 3'b111};
      n       = 5'($countones(en));
      sum_n   = 14'(words_ff) + 14'(n);
      sum_1   = 14'(words_ff) + 14'd1;
      act     = ACT_NONE;
      code    = ST_OK;
      if (item_ff.func == FUNC_BEGIN) begin
         act = ACT_CLEAR;
      end else if (item_ff.func == FUNC_PLANE || item_ff.func == FUNC_END) begin
         act = ACT_ERR;
         if (failed_ff) code = code_ff;
         else if (item_ff.func == FUNC_END) begin
            if (planes_ff == 5'd0) code = ST_INVALID;
            else if (cap_bad || sum_1 > 14'(cap_ff)) code = ST_CAPACITY;
            else act = ACT_END;
         end else begin
            if (6'(planes_ff) >= 6'(MAX_PLANES)) code = ST_PLANES;
            else if (cap_bad) code = ST_CAPACITY;
            else if (bad) code = ST_INVALID;
            else if (sum_n > 14'(cap_ff)) code = ST_CAPACITY;
            else act = ACT_PLANE;
         end
      end
   end

   // divider
   logic [31:0] d_num, d_den, d_quot, d_rem;
   logic        d_done;

   always_comb begin
      case (cmd.div_sel)
         DIV_SCALE_H: begin
            d_num = {3'd0, item_ff.source_width[12:0], 16'd0};
            d_den = 32'(item_ff.shown_width);
         end
         DIV_SCALE_V: begin
            d_num = {3'd0, item_ff.source_height[12:0], 16'd0};
            d_den = 32'(item_ff.shown_height);
         end
         DIV_RECIP_H: begin
            d_num = 32'hffffffff;
            d_den = qh_ff;
         end
         default: begin
            d_num = 32'hffffffff;
            d_den = qv_ff;
         end
      endcase
   end

   pdlb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (d_num),
      .denom (d_den),
      .done  (d_done),
      .quot  (d_quot),
      .rem   (d_rem)
   );

   // word of the current slot
   logic [31:0] slot_word, hdr;
   logic        nearest;
   logic [2:0]  sc;
   logic [NSLOT-1:0] rest;

   always_comb begin
      nearest = item_ff.scale_filter == FILT_NEAREST;
      sc      = (h_ff == SC_NONE && v_ff == SC_NONE) ? 3'd0 : scale_code(h_ff, v_ff);
      hdr     = 32'h40000000 | {3'd0, n_ff, 24'd0} | 32'h00004000 |
                ((h_ff == SC_NONE && v_ff == SC_NONE) ? 32'h00008000 : 32'd0) |
                32'h00001800 | {21'd0, sc, 8'd0} | {24'd0, sc, 5'd0} |
                (item_ff.pix_format == FMT_ARGB8888 ? 32'd7 : 32'd4);
      rest    = (en_ff >> cmd.slot) >> 1;
      case (cmd.slot)
         SLOT_HDR:   slot_word = hdr;
         SLOT_POS:   slot_word = {item_ff.place_y, item_ff.place_x};
         SLOT_ALPHA: slot_word = item_ff.pix_format == FMT_RGB565 ?
                                 (FIXED_ALPHA | OPAQUE_ALPHA) : OPAQUE_ALPHA;
         SLOT_DSIZE: slot_word = {item_ff.shown_height, item_ff.shown_width};
         SLOT_SSIZE: slot_word = {item_ff.source_height, item_ff.source_width};
         SLOT_CTX0, SLOT_CTX1, SLOT_CTX2, SLOT_CTX3: slot_word = CTX_WORD;
         SLOT_ADDR:  slot_word = item_ff.buffer_address;
         SLOT_PITCH: slot_word = 32'(item_ff.line_pitch);
         SLOT_LBM:   slot_word = {15'd0, planes_ff, 12'd0};
         SLOT_PPFH:  slot_word = ppf_word(qh_ff, rh_ff, item_ff.shown_width[12:0], nearest);
         SLOT_PPFV:  slot_word = ppf_word(qv_ff, rv_ff, item_ff.shown_height[12:0], nearest);
         SLOT_TZ0H:  slot_word = {3'd0, qh_ff[20:0], 8'd0};
         SLOT_TZ1H:  slot_word = 32'(ih_ff);
         SLOT_TZ0V:  slot_word = {3'd0, qv_ff[20:0], 8'd0};
         SLOT_TZ1V:  slot_word = 32'(iv_ff);
         default:    slot_word = nearest ? near_slot_ff : mitch_slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req;
      if (cmd.decide) begin
         h_ff  <= h_sc;
         v_ff  <= v_sc;
         n_ff  <= n;
         en_ff <= en;
      end
      if (cmd.div_save) begin
         case (cmd.div_sel)
            DIV_SCALE_H: begin qh_ff <= d_quot; rh_ff <= d_rem[12:0]; end
            DIV_SCALE_V: begin qv_ff <= d_quot; rv_ff <= d_rem[12:0]; end
            DIV_RECIP_H: ih_ff <= d_quot[15:0];
            default:     iv_ff <= d_quot[15:0];
         endcase
      end
      if (cmd.decide && (act == ACT_ERR || act == ACT_END)) begin
         out_ff.word            <= act == ACT_END ? END_WORD : 32'd0;
         out_ff.last            <= 1'b1;
         out_ff.status          <= act == ACT_END ? ST_OK : code;
         out_ff.fill_count      <= act == ACT_END ? sum_1[12:0] : words_ff;
         out_ff.nearest_needed  <= near_ff;
         out_ff.mitchell_needed <= mitch_ff;
      end else if (cmd.emit) begin
         out_ff.word            <= slot_word;
         out_ff.last            <= rest == '0;
         out_ff.status          <= ST_OK;
         out_ff.fill_count      <= words_ff + 13'd1;
         out_ff.nearest_needed  <= near_ff;
         out_ff.mitchell_needed <= mitch_ff;
      end

      if (reset) begin
         disp_w_ff     <= 13'd1920;
         disp_h_ff     <= 13'd1080;
         cap_ff        <= 13'd4096;
         near_slot_ff  <= '0;
         mitch_slot_ff <= '0;
         words_ff      <= '0;
         planes_ff     <= '0;
         near_ff       <= 1'b0;
         mitch_ff      <= 1'b0;
         failed_ff     <= 1'b0;
         code_ff       <= ST_OK;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DISPLAY_WIDTH:  disp_w_ff     <= csr_wdata[12:0];
               REG_DISPLAY_HEIGHT: disp_h_ff     <= csr_wdata[12:0];
               REG_LIST_CAPACITY:  cap_ff        <= csr_wdata[12:0];
               REG_NEAREST_SLOT:   near_slot_ff  <= csr_wdata;
               REG_MITCHELL_SLOT:  mitch_slot_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.decide) begin
            case (act)
               ACT_CLEAR: begin
                  words_ff  <= '0;
                  planes_ff <= '0;
                  near_ff   <= 1'b0;
                  mitch_ff  <= 1'b0;
                  failed_ff <= 1'b0;
                  code_ff   <= ST_OK;
               end
               ACT_ERR: begin
                  failed_ff <= 1'b1;
                  code_ff   <= code;
               end
               ACT_END: words_ff <= sum_1[12:0];
               ACT_PLANE: begin
                  if (any_ppf && nearest)  near_ff  <= 1'b1;
                  if (any_ppf && !nearest) mitch_ff <= 1'b1;
               end
               default: ;
            endcase
         end
         if (cmd.emit) words_ff <= words_ff + 13'd1;
         if (cmd.plane_done) planes_ff <= planes_ff + 5'd1;
         if ((cmd.decide && (act == ACT_ERR || act == ACT_END)) || cmd.emit)
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      sts.act      = act;
      sts.out_free = !out_valid_ff || !rsp_stall;
      sts.div_done = d_done;
      sts.slot_en  = en_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
endmodule
`default_nettype wire

### rtl/pdlb_ctrl.sv
// Controller: sequences capture, decision, the four divisions and word output.
// Depends on pdlb_pkg.
`default_nettype none
module pdlb_ctrl import pdlb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   typedef enum logic [2:0] {IDLE, DECIDE, DIV_GO, DIV_WAIT, EMIT} state_type;

   state_type  state_ff, state_in;
   logic [1:0] job_ff, job_in;
   logic [4:0] slot_ff, slot_in;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      cmd.div_sel = job_ff;
      cmd.slot    = slot_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = DECIDE;
            end
         end
         DECIDE: begin
            case (sts.act)
               ACT_ERR, ACT_END: begin
                  if (sts.out_free) begin
                     cmd.decide = 1'b1;
                     state_in   = IDLE;
                  end
               end
               ACT_PLANE: begin
                  cmd.decide = 1'b1;
                  job_in     = DIV_SCALE_H;
                  state_in   = DIV_GO;
               end
               default: begin
                  cmd.decide = 1'b1;
                  state_in   = IDLE;
               end
            endcase
         end
         DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = DIV_WAIT;
         end
         DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_save = 1'b1;
               job_in       = job_ff + 2'd1;
               if (job_ff == DIV_RECIP_V) begin
                  slot_in  = SLOT_HDR;
                  state_in = EMIT;
               end else begin
                  state_in = DIV_GO;
               end
            end
         end
         EMIT: begin
            if (!sts.slot_en[slot_ff] || sts.out_free) begin
               cmd.emit = sts.slot_en[slot_ff];
               slot_in  = slot_ff + 5'd1;
               if (slot_ff == SLOT_LAST) begin
                  cmd.plane_done = 1'b1;
                  state_in       = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      slot_ff <= slot_in;
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = state_ff != IDLE;
endmodule
`default_nettype wire

### rtl/plane_display_list_builder_core.sv
// Top level of the plane display list builder: controller plus datapath.
// Depends on pdlb_pkg, pdlb_ctrl, pdlb_dp (and pdlb_div inside the datapath).
`default_nettype none
// Takes one request word at a time. Begin and ignored words finish after
// capture and decision; end words and failing plane words give one response
// word, and their decision waits while the output is stalled. A valid plane
// runs four 32-step divisions on one shared radix-2 divider (two scale
// quotients, two reciprocals), then walks 22 word slots one a cycle, holding
// on an enabled slot while the output is stalled, and gives 8 to 18 response
// words. Errors stick until the next begin word. A plane that will not fit
// the list capacity is refused whole, before any of its words appear. A
// response word waits in an output register, so a stall holds only the word
// in hand. Configuration is written through csr_we, csr_index and csr_wdata,
// which the user must do while the block is idle; the block does not check.
module plane_display_list_builder_core import pdlb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   // sequencing
   pdlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // checks, list state, divisions and word building
   pdlb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

`ifndef NO_ASSERTIONS
   // never overwrite a word still waiting at the output
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free) else $error("emit over pending word");

   // only enabled slots produce words
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_en[cmd.slot]) else $error("emit of disabled slot");

   // an error word is a lone zero word
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_OK) |-> (rsp.last && rsp.word == 32'd0))
      else $error("bad error word");
`endif
endmodule
`default_nettype wire

### test/pdlb_checker.sv
// Checker for the plane display list builder: watches the request, response
// and register ports, predicts the list words and compares them in order.
// Depends on pdlb_pkg for the word types and codes.
`timescale 1ns / 100ps
module pdlb_checker import pdlb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int unsigned      pending,
   output int unsigned      mismatch_count
);

   // register copies
   logic [12:0] disp_w, disp_h, capacity;
   logic [31:0] nearest_slot, mitchell_slot;

   // list state
   int unsigned words_used, planes_placed;
   bit          nearest_flag, mitchell_flag, list_broken;
   logic [1:0]  held_code;

   rsp_type     expected_words[$];
   int unsigned fail_tally;

   function automatic logic [1:0] axis_mode(int unsigned src, int unsigned dst);
      if (src == dst) return SC_NONE;
      return (3 * dst >= 2 * src) ? SC_PPF : SC_TPZ;
   endfunction

   function automatic logic [2:0] mode_code(logic [1:0] h, logic [1:0] v);
      case ({h, v})
         {SC_TPZ, SC_PPF}:  return 3'd1;
         {SC_PPF, SC_TPZ}:  return 3'd2;
         {SC_TPZ, SC_TPZ}:  return 3'd3;
         {SC_PPF, SC_NONE}: return 3'd4;
         {SC_NONE, SC_PPF}: return 3'd5;
         {SC_NONE, SC_TPZ}: return 3'd6;
         {SC_TPZ, SC_NONE}: return 3'd7;
         default:           return 3'd0;
      endcase
   endfunction

   // 16.16 polyphase step with its start phase in the low seven bits
   function automatic logic [31:0] poly_word(int unsigned src, int unsigned dst, bit nr);
      logic [31:0] sf, step, err;
      int          phase;
      sf    = src << 16;
      step  = (sf / dst) & ~32'd1;
      err   = (sf - dst * step) >> 10;
      phase = -32 + int'(err >> 1);
      if (phase >= 64) phase = 63;
      return (nr ? 32'h8000_0000 : 32'h0) | 32'h4000_0000 |
             ((step & 32'h1ffff) << 8) | (32'(phase) & 32'h7f);
   endfunction

   function automatic logic [31:0] trap_step(int unsigned src, int unsigned dst);
      return dst < src ? (32'(src) << 16) / dst : 32'h10001;
   endfunction

   function automatic logic [31:0] trap_recip(int unsigned src, int unsigned dst);
      return (dst < src ? 32'hffff_ffff / trap_step(src, dst) : 32'hffff) & 32'hffff;
   endfunction

   task automatic push_word(logic [31:0] w, bit lst, logic [1:0] st, int unsigned cnt);
      rsp_type e;
      e.word            = w;
      e.last            = lst;
      e.status          = st;
      e.fill_count      = cnt[12:0];
      e.nearest_needed  = nearest_flag;
      e.mitchell_needed = mitchell_flag;
      expected_words.push_back(e);
   endtask

   task automatic refuse(logic [1:0] code);
      if (!list_broken) begin
         list_broken = 1;
         held_code   = code;
      end
      push_word(32'h0, 1'b1, held_code, words_used);
   endtask

   task automatic build_list_words(req_type r);
      logic [31:0] buf_w[18];
      int unsigned n, bpp, sw, sh, dw, dh, px, py, pitch;
      logic [1:0]  h, v;
      logic [2:0]  sc;
      logic [31:0] slot;
      bit          cap_bad, unity, nr, bad;
      cap_bad = capacity == 0 || capacity > MAX_LIST_WORDS;
      sw = r.source_width;  sh = r.source_height;
      dw = r.shown_width;   dh = r.shown_height;
      px = r.place_x;       py = r.place_y;
      pitch = r.line_pitch;
      n = 0;
      if (r.func == FUNC_BEGIN) begin
         words_used = 0; planes_placed = 0;
         nearest_flag = 0; mitchell_flag = 0;
         list_broken = 0; held_code = ST_OK;
         return;
      end
      if (r.func != FUNC_PLANE && r.func != FUNC_END) return;   // ignored word
      if (list_broken) begin
         refuse(held_code);
         return;
      end
      if (r.func == FUNC_END) begin
         if (planes_placed == 0) refuse(ST_INVALID);
         else if (cap_bad || words_used + 1 > capacity) refuse(ST_CAPACITY);
         else begin
            words_used++;
            push_word(END_WORD, 1'b1, ST_OK, words_used);
         end
         return;
      end
      if (planes_placed >= MAX_PLANES) begin
         refuse(ST_PLANES);
         return;
      end
      if (cap_bad) begin
         refuse(ST_CAPACITY);
         return;
      end
      bpp = r.pix_format == FMT_ARGB8888 ? 4 : 2;
      bad = r.buffer_address == 0 || r.buffer_address[0] ||
            sw == 0 || sw > DIM_MAX || sh == 0 || sh > DIM_MAX ||
            px > X_MAX || py > Y_MAX ||
            dw == 0 || dw > DIM_MAX || dh == 0 || dh > DIM_MAX ||
            disp_w == 0 || disp_h == 0 ||
            px > disp_w || dw > disp_w - px || py > disp_h || dh > disp_h - py ||
            sw > 32'hffff / bpp || pitch < sw * bpp ||
            (pitch & (bpp - 1)) != 0 || r.pix_format > 1 || r.scale_filter > 1;
      if (bad) begin
         refuse(ST_INVALID);
         return;
      end
      h = axis_mode(sw, dw);
      v = axis_mode(sh, dh);
      unity = h == SC_NONE && v == SC_NONE;
      nr = r.scale_filter == FILT_NEAREST;
      buf_w[n++] = 32'h0;
      buf_w[n++] = (32'(py) << 16) | px;
      buf_w[n++] = r.pix_format == FMT_RGB565 ? (FIXED_ALPHA | OPAQUE_ALPHA) : OPAQUE_ALPHA;
      if (!unity) buf_w[n++] = (32'(dh) << 16) | dw;
      buf_w[n++] = (32'(sh) << 16) | sw;
      buf_w[n++] = CTX_WORD;
      buf_w[n++] = r.buffer_address;
      buf_w[n++] = CTX_WORD;
      buf_w[n++] = pitch;
      if (v != SC_NONE) buf_w[n++] = planes_placed * 4096;
      if (h == SC_PPF) buf_w[n++] = poly_word(sw, dw, nr);
      if (v == SC_PPF) begin
         buf_w[n++] = poly_word(sh, dh, nr);
         buf_w[n++] = CTX_WORD;
      end
      if (h == SC_TPZ) begin
         buf_w[n++] = (trap_step(sw, dw) & 32'h1fffff) << 8;
         buf_w[n++] = trap_recip(sw, dw);
      end
      if (v == SC_TPZ) begin
         buf_w[n++] = (trap_step(sh, dh) & 32'h1fffff) << 8;
         buf_w[n++] = trap_recip(sh, dh);
         buf_w[n++] = CTX_WORD;
      end
      if (h == SC_PPF || v == SC_PPF) begin
         slot = nr ? nearest_slot : mitchell_slot;
         repeat (4) buf_w[n++] = slot;
      end
      // whole plane refused if it will not fit
      if (words_used + n > capacity) begin
         refuse(ST_CAPACITY);
         return;
      end
      sc = unity ? 3'd0 : mode_code(h, v);
      buf_w[0] = 32'h4000_0000 | (n << 24) | (32'd2 << 13) |
                 (unity ? 32'h8000 : 32'h0) | 32'h1000 | 32'h0800 |
                 (32'(sc) << 5) | (32'(sc) << 8) |
                 (r.pix_format == FMT_ARGB8888 ? 32'd7 : 32'd4);
      if (h == SC_PPF || v == SC_PPF) begin
         if (nr) nearest_flag = 1;
         else mitchell_flag = 1;
      end
      for (int i = 0; i < n; i++)
         push_word(buf_w[i], i + 1 == n, ST_OK, words_used + i + 1);
      words_used += n;
      planes_placed++;
   endtask

   task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         disp_w = 13'd1920; disp_h = 13'd1080; capacity = 13'd4096;
         nearest_slot = '0; mitchell_slot = '0;
         words_used = 0; planes_placed = 0;
         nearest_flag = 0; mitchell_flag = 0;
         list_broken = 0; held_code = ST_OK;
         expected_words.delete();
         fail_tally = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DISPLAY_WIDTH:  disp_w = csr_wdata[12:0];
               REG_DISPLAY_HEIGHT: disp_h = csr_wdata[12:0];
               REG_LIST_CAPACITY:  capacity = csr_wdata[12:0];
               REG_NEAREST_SLOT:   nearest_slot = csr_wdata;
               REG_MITCHELL_SLOT:  mitchell_slot = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp);
               fail_tally++;
            end else begin
               rsp_type e;
               e = expected_words.pop_front();
               check_field("word", e.word, rsp.word);
               check_field("last", e.last, rsp.last);
               check_field("status", e.status, rsp.status);
               check_field("fill_count", e.fill_count, rsp.fill_count);
               check_field("nearest_needed", e.nearest_needed, rsp.nearest_needed);
               check_field("mitchell_needed", e.mitchell_needed, rsp.mitchell_needed);
            end
         end
         if (req_valid && !req_stall) build_list_words(req);
      end
      pending        <= expected_words.size();
      mismatch_count <= fail_tally;
   end

endmodule

### test/tb_plane_display_list_builder_core.sv
// Testbench top for the plane display list builder: clock, reset, stimulus
// and verdict. Depends on pdlb_pkg, pdlb_checker and the block's RTL.
`timescale 1ns / 100ps
module tb_plane_display_list_builder_core;
   import pdlb_pkg::*;

   localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_stall;
   req_type     req = '0;
   logic        rsp_valid, rsp_stall = 0;
   rsp_type     rsp;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int unsigned pending, mismatch_count;

   // idle odds in percent for each side
   int unsigned send_idle = 0, recv_idle = 0;
   // display size as last written, for shaping planes that fit
   int unsigned disp_w = 1920, disp_h = 1080;
   int unsigned quiet_cycles = 0;

   plane_display_list_builder_core i_dut (
      .clock, .reset, .req_valid, .req_stall, .req,
      .rsp_valid, .rsp_stall, .rsp, .csr_we, .csr_index, .csr_wdata
   );

   pdlb_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req,
      .rsp_valid, .rsp_stall, .rsp, .csr_we, .csr_index, .csr_wdata,
      .pending, .mismatch_count
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle);
   end

   // watchdog: any handshake resets the count
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // one request word; valid stays high unless a gap follows
   task automatic send(req_type r);
      req       <= r;
      req_valid <= 1;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // drain every expected word, then let a begin or ignored word settle
   task automatic drain;
      req_valid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      if (idx == REG_DISPLAY_WIDTH) disp_w = val[12:0];
      if (idx == REG_DISPLAY_HEIGHT) disp_h = val[12:0];
   endtask

   task automatic setup(int unsigned w, int unsigned h, int unsigned cap);
      write_reg(REG_DISPLAY_WIDTH, w);
      write_reg(REG_DISPLAY_HEIGHT, h);
      write_reg(REG_LIST_CAPACITY, cap);
      write_reg(REG_NEAREST_SLOT, $urandom());
      write_reg(REG_MITCHELL_SLOT, $urandom());
   endtask

   function automatic req_type op(logic [1:0] f);
      req_type r;
      r = '0;
      r.func = f;
      return r;
   endfunction

   function automatic req_type plane(int unsigned fmt, int unsigned filt, logic [31:0] addr,
                                     int unsigned sw, int unsigned sh, int unsigned px,
                                     int unsigned py, int unsigned dw, int unsigned dh,
                                     int unsigned pitch);
      req_type r;
      r.func = FUNC_PLANE;
      r.pix_format = 2'(fmt); r.scale_filter = 2'(filt);
      r.buffer_address = addr;
      r.source_width = 16'(sw);  r.source_height = 16'(sh);
      r.place_x = 16'(px);       r.place_y = 16'(py);
      r.shown_width = 16'(dw);   r.shown_height = 16'(dh);
      r.line_pitch = 16'(pitch);
      return r;
   endfunction

   // mostly small sizes, now and then up to the limit
   function automatic int unsigned pick_dim(int unsigned lim);
      if ($urandom_range(9) == 0) return $urandom_range(lim, 1);
      return $urandom_range(lim < 64 ? lim : 64, 1);
   endfunction

   // source size that lands the axis on unity, polyphase, trapezoid or upscale
   function automatic int unsigned pick_src(int unsigned dst);
      int unsigned s;
      case ($urandom_range(3))
         0:       s = dst;
         1:       s = $urandom_range(dst * 3 / 2, dst);
         2:       s = $urandom_range(dst * 4, dst * 3 / 2 + 1);
         default: s = $urandom_range(dst, 1);
      endcase
      return s > 8191 ? 8191 : s;
   endfunction

   function automatic req_type good_plane();
      int unsigned lw, lh, dw, dh, sw, bpp, fmt, ymax;
      lw  = disp_w == 0 ? 1 : disp_w;
      lh  = disp_h == 0 ? 1 : disp_h;
      dw  = pick_dim(lw);
      dh  = pick_dim(lh);
      sw  = pick_src(dw);
      fmt = $urandom_range(1);
      bpp = fmt ? 4 : 2;
      ymax = lh - dh > 4095 ? 4095 : lh - dh;
      return plane(fmt, $urandom_range(1), ($urandom() & 32'hffff_fffe) | 32'h2,
                   sw, pick_src(dh), $urandom_range(lw - dw), $urandom_range(ymax),
                   dw, dh, sw * bpp + bpp * $urandom_range(3));
   endfunction

   // a well-formed plane with one field spoilt
   function automatic req_type bad_plane();
      req_type r;
      r = good_plane();
      case ($urandom_range(9))
         0: r.buffer_address = 0;
         1: r.buffer_address[0] = 1'b1;
         2: r.source_width = 0;
         3: r.source_height = 16'($urandom_range(65535, 8192));
         4: r.place_x = 16'($urandom_range(65535, 16384));
         5: r.place_y = 16'($urandom_range(65535, 4096));
         6: r.shown_width = 0;
         7: r.line_pitch = r.line_pitch - 16'd1;
         8: r.pix_format = 2'($urandom_range(3, 2));
         default: r.scale_filter = 2'($urandom_range(3, 2));
      endcase
      return r;
   endfunction

   task automatic random_items(int unsigned count);
      int unsigned pick;
      req_type     r;
      logic [159:0] raw;
      repeat (count) begin
         pick = $urandom_range(99);
         raw  = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         if (pick < 6) r = op(FUNC_BEGIN);
         else if (pick < 12) r = op(FUNC_END);
         else if (pick < 82) r = good_plane();
         else if (pick < 90) r = bad_plane();
         else r = req_type'(raw[$bits(req_type)-1:0]);
         send(r);
         // sender holds off now and then until the list has drained
         if ($urandom_range(99) < 3) drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: big display, full capacity
      setup(8191, 8191, 4096);
      send(op(FUNC_BEGIN));
      send(op(FUNC_END));                                    // end of an empty list
      send(op(FUNC_BEGIN));
      send(plane(0, 0, 32'h2, 1, 1, 0, 0, 1, 1, 2));          // smallest, unity
      send(plane(1, 1, 32'hffff_fffe, 8191, 8191, 0, 0, 8191, 8191, 32764));
      send(plane(0, 0, 32'h1000, 30, 30, 8191 - 24, 0, 24, 20, 60));   // polyphase both
      send(plane(1, 1, 32'h2000, 100, 90, 0, 4095, 10, 30, 400));      // trapezoid both
      send(plane(0, 1, 32'h3000, 10, 7, 5, 5, 40, 7, 20));             // upscale, one axis
      send(plane(1, 0, 32'h4000, 50, 200, 9, 9, 50, 20, 200));
      send(op(FUNC_IGNORE));                                 // ignored code
      send(op(FUNC_END));
      send(plane(0, 0, 32'h5000, 8, 8, 0, 0, 8, 8, 16));     // plane after end
      send(op(FUNC_END));
      send(op(FUNC_BEGIN));
      send(plane(0, 0, 32'h5001, 8, 8, 0, 0, 8, 8, 16));     // odd address
      send(op(FUNC_BEGIN));
      send(plane(0, 0, 32'h6000, 8192, 8, 0, 0, 8, 8, 16384));
      send(op(FUNC_BEGIN));
      send(plane(0, 0, 32'h6000, 8, 8, 16384, 0, 8, 8, 16)); // column beyond limit
      send(op(FUNC_BEGIN));
      send(plane(1, 0, 32'h6000, 8, 8, 0, 0, 8, 8, 34));     // pitch not word aligned
      send(op(FUNC_BEGIN));
      send(plane(2, 0, 32'h6000, 8, 8, 0, 0, 8, 8, 32));     // unknown format
      send(op(FUNC_BEGIN));
      send(plane(0, 3, 32'h6000, 8, 8, 0, 0, 8, 8, 16));     // unknown filter
      drain();

      // sender idles lightly, receiver heavily
      send_idle = 10; recv_idle = 67;
      setup(1920, 1080, 4096);
      send(op(FUNC_BEGIN));
      random_items(40);
      drain();

      // roles swapped, small display and a tight list
      send_idle = 67; recv_idle = 10;
      setup(100, 80, 50);
      send(op(FUNC_BEGIN));
      random_items(40);
      drain();

      // no idling: fill past the plane limit, then more random words
      send_idle = 0; recv_idle = 0;
      setup(8191, 8191, 4096);
      send(op(FUNC_BEGIN));
      repeat (17) send(good_plane());
      send(op(FUNC_END));
      send(op(FUNC_BEGIN));
      random_items(30);
      drain();

      // zero display and zero capacity reject everything
      setup(0, 1080, 0);
      send(op(FUNC_BEGIN));
      random_items(6);
      drain();
      // capacity above the list size, zero height
      setup(1920, 0, 8191);
      send(op(FUNC_BEGIN));
      random_items(6);
      drain();

      if (mismatch_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### plane_display_list_builder_core.f
rtl/pdlb_pkg.sv
rtl/pdlb_div.sv
rtl/pdlb_dp.sv
rtl/pdlb_ctrl.sv
rtl/plane_display_list_builder_core.sv
test/pdlb_checker.sv
test/tb_plane_display_list_builder_core.sv
